// File: rtl/core/rtcp_generic_nack_parser_macros.svh
// Assertion macros shared by the NACK parser RTL.
`ifndef RTCP_GENERIC_NACK_PARSER_MACROS_SVH
`define RTCP_GENERIC_NACK_PARSER_MACROS_SVH

// Implication checked on every rising clock edge outside reset.
`define RNACK_ASSERT_PROP(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition that must never be true outside reset.
`define RNACK_ASSERT_NEVER(label, clk, rst_n, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// File: rtl/core/rnack_pkg.sv
// Shared types and constants of the RTCP Generic NACK parser.
package rnack_pkg;

	// Packet type range and the Generic NACK selector
	localparam logic [7:0] TYPE_FIRST_KNOWN  = 8'd200;
	localparam logic [7:0] TYPE_LAST_KNOWN   = 8'd206;
	localparam logic [7:0] TYPE_TRANSPORT_FB = 8'd205;
	localparam logic [4:0] FMT_GENERIC_NACK  = 5'd1;

	// Byte positions inside a message header
	localparam logic [17:0] POS_FMT     = 18'd0;
	localparam logic [17:0] POS_TYPE    = 18'd1;
	localparam logic [17:0] POS_LEN_HI  = 18'd2;
	localparam logic [17:0] POS_LEN_LO  = 18'd3;
	// Word index of the media SSRC (bytes 8..11) and first FCI word (byte 12)
	localparam logic [15:0] WORD_MEDIA_SSRC = 16'd2;
	localparam logic [15:0] WORD_FCI_FIRST  = 16'd3;

	localparam int unsigned BLP_BITS  = 16;
	localparam int unsigned BLP_IDX_W = $clog2(BLP_BITS);

	// One FCI word plus the media SSRC it belongs to
	typedef struct packed {
		logic [15:0] pid;
		logic [15:0] blp;
		logic [31:0] ssrc;
	} fci_entry_t;

	// Queue status seen by the front and back sections
	typedef struct packed {
		logic full;
		logic empty;
	} queue_status_t;

endpackage

// File: rtl/core/rnack_front.sv
// Byte-wise RTCP header and message walker that extracts Generic NACK FCI words.
`include "rtcp_generic_nack_parser_macros.svh"

module rnack_front (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic [7:0]                data_byte,
	input  logic                      end_of_datagram,
	input  rnack_pkg::queue_status_t  q_status,
	output logic                      push,
	output rnack_pkg::fci_entry_t     push_entry
);

	logic [17:0] pos_q, pos_d;
	logic [17:0] len_q, len_d;
	logic [7:0]  ptype_q, ptype_d;
	logic [4:0]  fmt_q, fmt_d;
	logic [31:0] ssrc_q, ssrc_d;
	logic [31:0] fci_q, fci_d;
	logic        halted_q, halted_d;
	logic        is_nack;
	logic        fci_done;
	logic        accept;
	logic [18:0] msg_end;

	// Hold the byte whenever the queue has no room for a possible FCI
	assign in_stall = q_status.full;
	assign accept   = in_valid && !in_stall;
	assign is_nack  = (ptype_q == rnack_pkg::TYPE_TRANSPORT_FB) &&
	                  (fmt_q == rnack_pkg::FMT_GENERIC_NACK);

	// Per-byte parse step
	always_comb begin
		pos_d    = pos_q;
		len_d    = len_q;
		ptype_d  = ptype_q;
		fmt_d    = fmt_q;
		ssrc_d   = ssrc_q;
		fci_d    = fci_q;
		halted_d = halted_q;
		fci_done = 1'b0;
		msg_end  = 19'd0;
		if (!halted_q) begin
			unique case (pos_q)
				rnack_pkg::POS_FMT: begin
					fmt_d = data_byte[4:0];
				end
				rnack_pkg::POS_TYPE: begin
					ptype_d = data_byte;
					if (data_byte < rnack_pkg::TYPE_FIRST_KNOWN ||
					    data_byte > rnack_pkg::TYPE_LAST_KNOWN) begin
						halted_d = 1'b1;
					end
				end
				rnack_pkg::POS_LEN_HI: begin
					len_d = {2'b00, data_byte, 8'h00};
				end
				rnack_pkg::POS_LEN_LO: begin
					len_d = {len_q[15:8], data_byte, 2'b00};
				end
				default: begin
					if (is_nack) begin
						if (pos_q[17:2] == rnack_pkg::WORD_MEDIA_SSRC) begin
							ssrc_d = {ssrc_q[23:0], data_byte};
						end else if (pos_q[17:2] >= rnack_pkg::WORD_FCI_FIRST) begin
							fci_d    = {fci_q[23:0], data_byte};
							fci_done = (pos_q[1:0] == 2'b11);
						end
					end
				end
			endcase
			// Wrap to the next message header after the last payload byte
			msg_end = {1'b0, len_d} + 19'd3;
			if (!halted_d) begin
				if (pos_q >= rnack_pkg::POS_LEN_LO && {1'b0, pos_q} == msg_end) begin
					pos_d = '0;
				end else begin
					pos_d = pos_q + 18'd1;
				end
			end
		end
	end

	assign push            = accept && fci_done;
	assign push_entry.pid  = fci_d[31:16];
	assign push_entry.blp  = fci_d[15:0];
	assign push_entry.ssrc = ssrc_q;

	// Parse state; the end-of-datagram byte returns everything to reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= '0;
			len_q    <= '0;
			ptype_q  <= '0;
			fmt_q    <= '0;
			ssrc_q   <= '0;
			fci_q    <= '0;
			halted_q <= 1'b0;
		end else if (accept) begin
			if (end_of_datagram) begin
				pos_q    <= '0;
				len_q    <= '0;
				ptype_q  <= '0;
				fmt_q    <= '0;
				ssrc_q   <= '0;
				fci_q    <= '0;
				halted_q <= 1'b0;
			end else begin
				pos_q    <= pos_d;
				len_q    <= len_d;
				ptype_q  <= ptype_d;
				fmt_q    <= fmt_d;
				ssrc_q   <= ssrc_d;
				fci_q    <= fci_d;
				halted_q <= halted_d;
			end
		end
	end

	// Once halted, the position only moves through the datagram-end reset
	`RNACK_ASSERT_PROP(a_halt_freezes_pos, clk, arst_n, halted_q && !(accept && end_of_datagram) |=> $stable(pos_q), "position moved while halted")

endmodule

// File: rtl/core/rnack_queue.sv
// Two-entry queue of FCI words between the byte walker and the expander.
`include "rtcp_generic_nack_parser_macros.svh"

module rnack_queue (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      push,
	input  rnack_pkg::fci_entry_t     push_entry,
	input  logic                      pop,
	output rnack_pkg::fci_entry_t     head,
	output rnack_pkg::queue_status_t  status
);

	rnack_pkg::fci_entry_t mem_q [2];
	logic                  wr_ptr_q;
	logic                  rd_ptr_q;
	logic [1:0]            count_q;

	assign status.full  = (count_q == 2'd2);
	assign status.empty = (count_q == 2'd0);
	assign head         = mem_q[rd_ptr_q];

	// Storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

	`RNACK_ASSERT_NEVER(a_no_push_full, clk, arst_n, push && status.full, "push into full queue")
	`RNACK_ASSERT_NEVER(a_no_pop_empty, clk, arst_n, pop && status.empty, "pop from empty queue")
	`RNACK_ASSERT_PROP(a_count_ptrs, clk, arst_n, (count_q == 2'd1) |-> (wr_ptr_q != rd_ptr_q), "pointers disagree with count")

endmodule

// File: rtl/core/rnack_back.sv
// Expands one FCI word into the PID and one sequence number per set BLP bit.
`include "rtcp_generic_nack_parser_macros.svh"

module rnack_back (
	input  logic                      clk,
	input  logic                      arst_n,
	input  rnack_pkg::fci_entry_t     head,
	input  rnack_pkg::queue_status_t  q_status,
	output logic                      pop,
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic [15:0]               seq_number,
	output logic [31:0]               media_ssrc,
	output logic                      last_of_fci
);

	logic                                active_q;
	logic [15:0]                         pid_q;
	logic [rnack_pkg::BLP_BITS-1:0]      mask_q;
	logic [31:0]                         ssrc_q;
	logic                                out_valid_q;
	logic [15:0]                         seq_q;
	logic [31:0]                         out_ssrc_q;
	logic                                last_q;
	logic                                slot_free;
	logic                                step;
	logic [rnack_pkg::BLP_IDX_W-1:0]     low_idx;
	logic [rnack_pkg::BLP_BITS-1:0]      rest;

	assign slot_free = !out_valid_q || !out_stall;
	assign step      = active_q && slot_free;
	assign pop       = !active_q && !q_status.empty && slot_free;

	// Lowest set bit of the remaining BLP mask
	always_comb begin
		low_idx = '0;
		for (int i = rnack_pkg::BLP_BITS - 1; i >= 0; i--) begin
			if (mask_q[i]) begin
				low_idx = rnack_pkg::BLP_IDX_W'(i);
			end
		end
	end
	assign rest = mask_q & (mask_q - rnack_pkg::BLP_BITS'(1));

	// Expansion state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
		end else if (pop) begin
			active_q <= (head.blp != '0);
		end else if (step) begin
			active_q <= (rest != '0);
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			pid_q  <= head.pid;
			mask_q <= head.blp;
			ssrc_q <= head.ssrc;
		end else if (step) begin
			mask_q <= rest;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (slot_free) begin
			out_valid_q <= pop || step;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			seq_q      <= head.pid;
			out_ssrc_q <= head.ssrc;
			last_q     <= (head.blp == '0);
		end else if (step) begin
			seq_q      <= pid_q + 16'(low_idx) + 16'd1;
			out_ssrc_q <= ssrc_q;
			last_q     <= (rest == '0);
		end
	end

	assign out_valid   = out_valid_q;
	assign seq_number  = seq_q;
	assign media_ssrc  = out_ssrc_q;
	assign last_of_fci = last_q;

	`RNACK_ASSERT_PROP(a_active_has_bits, clk, arst_n, active_q |-> (mask_q != '0), "active expansion with empty mask")
	`RNACK_ASSERT_NEVER(a_pop_while_active, clk, arst_n, pop && active_q, "new FCI taken during expansion")

endmodule

// File: rtl/core/rtcp_generic_nack_parser.sv
// The first result of an FCI is written into the FCI queue and then into the output
// register after the last byte of that FCI is accepted; a busy expander or out_stall
// delays it. Bytes are taken one per cycle while in_stall is low; each FCI gives
// 1 + popcount(BLP) results, one per cycle from the expander while out_stall is low.
// A two-entry FCI queue lets bytes flow while the expander drains; bytes stall when full.
// Reset (arst_n low) clears parse state, queue pointers and output valid at once.
module rtcp_generic_nack_parser (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  data_byte,
	input  logic        end_of_datagram,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [15:0] seq_number,
	output logic [31:0] media_ssrc,
	output logic        last_of_fci
);

	rnack_pkg::queue_status_t q_status;
	rnack_pkg::fci_entry_t    push_entry;
	rnack_pkg::fci_entry_t    head;
	logic                     push;
	logic                     pop;

	// Byte walker
	rnack_front u_front (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.data_byte       (data_byte),
		.end_of_datagram (end_of_datagram),
		.q_status        (q_status),
		.push            (push),
		.push_entry      (push_entry)
	);

	// FCI queue
	rnack_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.pop        (pop),
		.head       (head),
		.status     (q_status)
	);

	// Sequence number expander
	rnack_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head        (head),
		.q_status    (q_status),
		.pop         (pop),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.seq_number  (seq_number),
		.media_ssrc  (media_ssrc),
		.last_of_fci (last_of_fci)
	);

endmodule
